### rtl/sitoa_pkg.sv
// Package with the shared types and constants of the integer to decimal text converter.
`timescale 1ns / 1ps
package sitoa_pkg;

	// Character codes of the emitted text.
	localparam logic [5:0] ASCII_ZERO  = 6'd48;
	localparam logic [5:0] ASCII_MINUS = 6'd45;

	// Divide by ten as a multiplication by the rounded reciprocal 2^35 / 10.
	localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // take a new input item
		logic step;      // one divide-by-ten digit step
		logic sel_sign;  // present the minus sign on the output
		logic advance;   // a digit was taken, move to the next one
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic conv_last; // this digit step is the final one
		logic negative;  // the current item is negative
		logic idx_zero;  // the digit on the output is the least significant
	} sts_t;

endpackage

### rtl/signed_int_to_decimal_ascii_core.sv
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
// Takes one two's-complement integer per input item and returns its decimal text, one
// character per output item, most significant first: a leading '-' for negative values,
// no leading zeros, '0' for zero, and tlast on the final character. Items are handled one
// at a time. After the input item is taken, the shared divide-by-ten unit produces one
// digit per cycle into a small digit store, then one character leaves per cycle while
// the sink is ready. Only the least significant MAX_DIGITS digits are kept when the
// value needs more.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_core #(
	parameter int MAX_DIGITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [5:0] ascii_char, [7:6] zero
	output logic        m_axis_tlast   // last_char
);
	import sitoa_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic [5:0] ascii_char;

	// Controller.
	sitoa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.cmd       (cmd)
	);

	// Datapath.
	sitoa_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (s_axis_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.ascii_char (ascii_char),
		.last_char  (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, ascii_char};

endmodule

### rtl/sitoa_ctrl.sv
// Controller state machine of the integer to decimal text converter.
`timescale 1ns / 1ps
module sitoa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_ready,
	input  sitoa_pkg::sts_t  sts,
	output logic             in_ready,
	output logic             out_valid,
	output sitoa_pkg::cmd_t  cmd
);
	import sitoa_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_CONV;
				end
			end
			ST_CONV: begin
				if (sts.conv_last) begin
					state_nxt = sts.negative ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (out_ready) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_ready && sts.idx_zero) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CONV: begin
				cmd.step = 1'b1;
			end
			ST_SIGN: begin
				out_valid    = 1'b1;
				cmd.sel_sign = 1'b1;
			end
			ST_EMIT: begin
				out_valid   = 1'b1;
				cmd.advance = out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

### rtl/sitoa_dp.sv
// Datapath of the integer to decimal text converter: magnitude, divide by ten, digit store.
`timescale 1ns / 1ps
module sitoa_dp #(
	parameter int MAX_DIGITS = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      value,
	input  sitoa_pkg::cmd_t  cmd,
	output sitoa_pkg::sts_t  sts,
	output logic [5:0]       ascii_char,
	output logic             last_char
);
	import sitoa_pkg::*;

	localparam int IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam logic [IdxW-1:0] IdxLast = IdxW'(MAX_DIGITS - 1);

	logic [31:0]     mag_q;
	logic            neg_q;
	logic [IdxW-1:0] idx_q;
	logic [3:0]      digit_store_q [MAX_DIGITS];

	logic [63:0]     prod;
	logic [31:0]     quot;
	logic [3:0]      ten_quot_lo;
	logic [3:0]      rem;
	logic [3:0]      rd_digit;

	// Quotient by reciprocal multiplication; the remainder needs only four bits.
	assign prod        = {32'd0, mag_q} * {32'd0, RECIP_TEN};
	assign quot        = 32'(prod[63:RECIP_SHIFT]);
	assign ten_quot_lo = {quot[2:0], 1'b0} + {quot[0], 3'b000};
	assign rem         = mag_q[3:0] - ten_quot_lo;

	// Magnitude, sign and digit index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
			neg_q <= 1'b0;
			idx_q <= '0;
		end else if (cmd.load) begin
			neg_q <= value[31];
			mag_q <= value[31] ? (~value + 32'd1) : value;
			idx_q <= '0;
		end else if (cmd.step) begin
			mag_q <= quot;
			if (!sts.conv_last) begin
				idx_q <= idx_q + IdxW'(1);
			end
		end else if (cmd.advance && (idx_q != '0)) begin
			idx_q <= idx_q - IdxW'(1);
		end
	end

	// Digit store, least significant digit at entry zero.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			digit_store_q[idx_q] <= rem;
		end
	end

	assign rd_digit = digit_store_q[idx_q];

	// Status for the controller.
	assign sts.conv_last = (quot == 32'd0) || (idx_q == IdxLast);
	assign sts.negative  = neg_q;
	assign sts.idx_zero  = (idx_q == '0);

	// Output character.
	assign ascii_char = cmd.sel_sign ? ASCII_MINUS : (ASCII_ZERO + {2'b00, rd_digit});
	assign last_char  = !cmd.sel_sign && (idx_q == '0);

endmodule

### rtl/sitoa_checker.sv
// Port-level checker of the integer to decimal text converter, bound to the top level.
`timescale 1ns / 1ps
module sitoa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);
	import sitoa_pkg::*;

	// A stalled output item holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	// A new item is taken only while no character is pending.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("input taken while output pending");

	// The first cycle after an item is taken is a digit step, no output yet.
	a_conv_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid && !s_axis_tready)
		else $error("output right after input");

	// The minus sign is never the final character.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[5:0] == ASCII_MINUS) |-> !m_axis_tlast)
		else $error("minus sign flagged last");

	// After the final character the block is ready for the next item.
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("not ready after final character");

endmodule

bind signed_int_to_decimal_ascii_core sitoa_checker u_sitoa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
